// File: rtl/mkvl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mkvl_pkg
// Shared types and constants for the metadata key/value lookup.
// ----------------------------------------------------------------------------
package mkvl_pkg;

  localparam int MAX_KEY_LENGTH = 8;
  localparam int CHAR_W         = 8;
  localparam int KEY_LEN_W      = 4;
  localparam int KEY_CHARS_W    = 64;
  localparam int POS_W          = 4;
  localparam int KEY_IDX_W      = 3;
  localparam int CFG_INDEX_W    = 4;
  localparam int CFG_DATA_W     = 64;

  localparam logic [CHAR_W-1:0] EQUALS_CHAR = 8'h3D;
  localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'h20;
  localparam logic [CHAR_W-1:0] TAB_CHAR    = 8'h09;
  localparam logic [CHAR_W-1:0] CR_CHAR     = 8'h0D;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_CHARS  = 4'd1;

  typedef enum logic [3:0] {
    MODE_GAP   = 4'b0001,
    MODE_KEY   = 4'b0010,
    MODE_VALUE = 4'b0100,
    MODE_SKIP  = 4'b1000
  } scan_mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0] value_char;
    logic              char_valid;
    logic              record_end;
    logic              found;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/mkvl_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mkvl_scan
// Token matcher: holds the scan state and forms the result for one character.
// ----------------------------------------------------------------------------
module mkvl_scan
  import mkvl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic [CHAR_W-1:0]      ch,
  input  wire logic                   last,
  input  wire logic [KEY_LEN_W-1:0]   key_length,
  input  wire logic [KEY_CHARS_W-1:0] key_chars,
  output result_t                     result,
  output logic                        produce
);

  scan_mode_t       scan_mode, scan_mode_next;
  logic [POS_W-1:0] match_position, match_position_next;
  logic             key_found, key_found_next;

  logic              blank;
  logic              too_long;
  logic [POS_W-1:0]  pos_cur;
  logic [CHAR_W-1:0] key_byte;
  scan_mode_t        cmp_mode;
  logic [POS_W-1:0]  cmp_pos;
  logic              emit;

  assign blank    = (ch == SPACE_CHAR) || ((ch >= TAB_CHAR) && (ch <= CR_CHAR));
  assign too_long = key_length > KEY_LEN_W'(MAX_KEY_LENGTH);
  assign pos_cur  = (scan_mode == MODE_GAP) ? '0 : match_position;
  assign key_byte = key_chars[pos_cur[KEY_IDX_W-1:0]*CHAR_W +: CHAR_W];

  // one key compare step
  always_comb begin
    cmp_pos = pos_cur;
    if (too_long) begin
      cmp_mode = MODE_SKIP;
    end else if (pos_cur < key_length) begin
      if (ch == key_byte) begin
        cmp_pos  = pos_cur + POS_W'(1);
        cmp_mode = MODE_KEY;
      end else begin
        cmp_mode = MODE_SKIP;
      end
    end else if (ch == EQUALS_CHAR) begin
      cmp_mode = MODE_VALUE;
    end else begin
      cmp_mode = MODE_SKIP;
    end
  end

  always_comb begin
    scan_mode_next      = scan_mode;
    match_position_next = match_position;
    key_found_next      = key_found;
    emit                = 1'b0;
    if (blank) begin
      scan_mode_next = MODE_GAP;
    end else begin
      unique case (scan_mode)
        MODE_GAP: begin
          if (key_found) begin
            scan_mode_next = MODE_SKIP;
          end else begin
            scan_mode_next      = cmp_mode;
            match_position_next = cmp_pos;
          end
        end
        MODE_KEY: begin
          scan_mode_next      = cmp_mode;
          match_position_next = cmp_pos;
        end
        MODE_VALUE: begin
          emit           = 1'b1;
          key_found_next = 1'b1;
        end
        MODE_SKIP: ;
        default: ;
      endcase
    end
  end

  assign produce           = emit || last;
  assign result.value_char = emit ? ch : '0;
  assign result.char_valid = emit;
  assign result.record_end = last;
  assign result.found      = last && key_found_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= MODE_GAP;
      match_position <= '0;
      key_found      <= 1'b0;
    end else if (step) begin
      if (last) begin
        scan_mode      <= MODE_GAP;
        match_position <= '0;
        key_found      <= 1'b0;
      end else begin
        scan_mode      <= scan_mode_next;
        match_position <= match_position_next;
        key_found      <= key_found_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_found_no_key: assert property (@(posedge clk) disable iff (rst)
    key_found |-> (scan_mode != MODE_KEY))
    else $error("key compare after a value was found");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    match_position <= POS_W'(MAX_KEY_LENGTH))
    else $error("match position beyond key length");

  a_record_reset: assert property (@(posedge clk) disable iff (rst)
    (step && last) |=> (scan_mode == MODE_GAP && match_position == '0 && !key_found))
    else $error("scan state not cleared after record end");
`endif

endmodule
`default_nettype wire

// File: rtl/metadata_key_value_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// metadata_key_value_lookup
// Extracts the value of the first Key=Value token of a record whose key matches the configured key.
// ----------------------------------------------------------------------------
// channel   dir  handshake           contents
// s_axis    in   tvalid/tready       tdata = ch, tlast = last_of_record
// m_axis    out  tvalid/tready       tdata = value_char, tlast = record_end,
//                                    tuser = char_valid, found
// cfg       in   cfg_wr_en           cfg_index, cfg_data (no wait, no read)
//
// One word per cycle sustained while the result register is not stalled; each word passes
// through the input register, then the match logic into the result register.
// Words that give no result leave the input register without stalling.
// A stalled result register holds the next word that gives a result in the input register.
// rst is synchronous, active high; key registers reset to zero.
// ----------------------------------------------------------------------------
module metadata_key_value_lookup
  import mkvl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [CHAR_W-1:0]      s_axis_tdata,   // [7:0] ch
  input  wire logic                   s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [CHAR_W-1:0]           m_axis_tdata,   // [7:0] value_char
  output logic [1:0]                  m_axis_tuser,   // [0] char_valid, [1] found
  output logic                        m_axis_tlast,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [KEY_LEN_W-1:0]   key_length;
  logic [KEY_CHARS_W-1:0] key_chars;

  logic              in_valid;
  logic [CHAR_W-1:0] in_ch;
  logic              in_last;

  logic    out_valid;
  result_t out_word;

  result_t result;
  logic    produce;
  logic    step;

  assign step          = in_valid && (!out_valid || m_axis_tready || !produce);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= '0;
      key_chars  <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_KEY_LENGTH) begin
        key_length <= cfg_data[KEY_LEN_W-1:0];
      end else if (cfg_index == REG_KEY_CHARS) begin
        key_chars <= cfg_data[KEY_CHARS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_ch   <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  mkvl_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .ch         (in_ch),
    .last       (in_last),
    .key_length (key_length),
    .key_chars  (key_chars),
    .result     (result),
    .produce    (produce)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && produce) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && produce) begin
      out_word <= result;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_word.value_char;
  assign m_axis_tlast    = out_word.record_end;
  assign m_axis_tuser[0] = out_word.char_valid;
  assign m_axis_tuser[1] = out_word.found;

`ifndef NO_ASSERTIONS
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.char_valid) |-> out_word.record_end)
    else $error("result word with neither value nor record end");

  a_found_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.found) |-> out_word.record_end)
    else $error("found flag outside record end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready && in_valid && produce) |-> !step)
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire
